// ===== design/uls_pkg.sv =====
// uls_pkg: shared types, constants and helpers for the UTF-8 likelihood scorer.
// No dependencies; imported by uls_ctrl, uls_dp and the top level.
package uls_pkg;

	localparam int unsigned ULS_COUNT_WIDTH = 32;	// default saturating counter width
	localparam int unsigned WIN_DEPTH       = 6;	// lookahead window, longest lead
	localparam int unsigned OUT_CNT_W       = 32;	// count fields on the result port
	localparam int unsigned CNT_WIDE_W      = 64;	// widest counter allowed
	localparam int unsigned PCT_W           = 7;	// percent field, also quotient bits

	localparam logic [1:0] CONT_TAG  = 2'h2;	// 10xxxxxx
	localparam logic [2:0] LEAD2_TAG = 3'h6;	// 110xxxxx
	localparam logic [3:0] LEAD3_TAG = 4'hE;	// 1110xxxx
	localparam logic [4:0] LEAD4_TAG = 5'h1E;	// 11110xxx
	localparam logic [5:0] LEAD5_TAG = 6'h3E;	// 111110xx
	localparam logic [6:0] LEAD6_TAG = 7'h7E;	// 1111110x

	localparam logic [6:0] PCT_SCALE = 7'd100;

	// controller -> datapath
	typedef struct packed {
		logic load;		// append the input byte to the window
		logic step;		// decide the head of the window
		logic drain;		// end of stream: short leads fail
		logic div_init;		// latch numerator/denominator for percent
		logic div_step;		// one restoring-division iteration
		logic out_load;		// capture result, clear counters
	} uls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic can_step;		// head decidable this cycle
		logic div_last;		// final quotient bit in progress
	} uls_sts_t;

	// sequence length of a lead byte, 0 if not a multibyte lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b[7:5] == LEAD2_TAG)      len = 3'd2;
		else if (b[7:4] == LEAD3_TAG) len = 3'd3;
		else if (b[7:3] == LEAD4_TAG) len = 3'd4;
		else if (b[7:2] == LEAD5_TAG) len = 3'd5;
		else if (b[7:1] == LEAD6_TAG) len = 3'd6;
		return len;
	endfunction

endpackage

// ===== design/uls_ctrl.sv =====
// uls_ctrl: sequencing FSM for the scorer (byte intake, head decisions,
// percent division, result handoff). Depends on uls_pkg.
module uls_ctrl import uls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     last_byte,
	output logic     out_valid,
	input  logic     out_ready,
	output uls_cmd_t cmd,
	input  uls_sts_t sts
);

	typedef enum logic [3:0] {
		S_PROC = 4'b0001,
		S_PREP = 4'b0010,
		S_DIV  = 4'b0100,
		S_HOLD = 4'b1000
	} uls_state_t;

	uls_state_t state_q, state_d;
	logic       drain_q;
	logic       out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.drain = drain_q;
		in_ready  = 1'b0;
		state_d   = state_q;
		case (state_q)
			S_PROC: begin
				if (sts.can_step) begin
					cmd.step = 1'b1;
				end else if (drain_q) begin
					state_d = S_PREP;
				end else begin
					in_ready = 1'b1;
					cmd.load = in_valid;
				end
			end
			S_PREP: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_PROC;
				end
			end
			default: state_d = S_PROC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_PROC;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)          drain_q <= last_byte;
			else if (cmd.out_load) drain_q <= 1'b0;
			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/uls_dp.sv =====
// uls_dp: lookahead window, saturating counters, restoring divider for the
// percent figure and the result register. Depends on uls_pkg.
module uls_dp import uls_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = ULS_COUNT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  uls_cmd_t             cmd,
	output uls_sts_t             sts,
	input  logic [7:0]           data_byte,
	output logic [OUT_CNT_W-1:0] valid_sequences,
	output logic [OUT_CNT_W-1:0] invalid_bytes,
	output logic [PCT_W-1:0]     percent_valid
);

	localparam int unsigned RW = COUNT_WIDTH + 8;	// holds 100*count and divisor<<6

	logic [7:0]             win_q [WIN_DEPTH];
	logic [2:0]             fill_q;
	logic [COUNT_WIDTH-1:0] vcnt_q, icnt_q;
	logic [RW-1:0]          rem_q, den_q;
	logic [PCT_W-1:0]       quo_q;
	logic [2:0]             dcnt_q;
	logic                   zero_q;
	logic [OUT_CNT_W-1:0]   vout_q, iout_q;
	logic [PCT_W-1:0]       pct_q;

	// head decision
	logic [7:0]  head;
	logic [2:0]  len;
	logic        cont_ok, short_seq, inc_v, inc_i;
	logic [2:0]  drop_n;
	logic [3:0]  idx [WIN_DEPTH];
	logic [7:0]  win_sh [WIN_DEPTH];

	always_comb begin
		head      = win_q[0];
		len       = lead_len(head);
		short_seq = (fill_q < len);
		cont_ok   = 1'b1;
		for (int k = 1; k < WIN_DEPTH; k++) begin
			if (3'(k) < len && win_q[k][7:6] != CONT_TAG) cont_ok = 1'b0;
		end
		inc_v  = 1'b0;
		inc_i  = 1'b0;
		drop_n = 3'd1;
		if (head[7]) begin
			if (len == 3'd0 || short_seq || !cont_ok) begin
				inc_i = 1'b1;
			end else begin
				inc_v  = 1'b1;
				drop_n = len;
			end
		end
		sts.can_step = (fill_q != 3'd0) && !(len != 3'd0 && short_seq && !cmd.drain);
		sts.div_last = (dcnt_q == 3'(PCT_W - 1));
		for (int i = 0; i < WIN_DEPTH; i++) begin
			idx[i]    = 4'(i) + 4'(drop_n);
			win_sh[i] = (idx[i] < 4'(WIN_DEPTH)) ? win_q[idx[i][2:0]] : win_q[i];
		end
	end

	// window storage, no reset on contents
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[fill_q] <= data_byte;
		end else if (cmd.step) begin
			win_q <= win_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vcnt_q <= '0;
			icnt_q <= '0;
		end else if (cmd.out_load) begin
			fill_q <= '0;
			vcnt_q <= '0;
			icnt_q <= '0;
		end else if (cmd.load) begin
			fill_q <= fill_q + 3'd1;
		end else if (cmd.step) begin
			fill_q <= fill_q - drop_n;
			if (inc_v && vcnt_q != '1) vcnt_q <= vcnt_q + 1'b1;
			if (inc_i && icnt_q != '1) icnt_q <= icnt_q + 1'b1;
		end
	end

	// percent = floor(100*v / (v+i)), one quotient bit per cycle
	logic [RW-1:0]         v_ext, num, den;
	logic                  ge;
	logic [CNT_WIDE_W-1:0] v_wide, i_wide;

	always_comb begin
		v_ext  = RW'(vcnt_q);
		num    = (v_ext << 6) + (v_ext << 5) + (v_ext << 2);
		den    = (RW'(vcnt_q) + RW'(icnt_q)) << (PCT_W - 1);
		ge     = (rem_q >= den_q);
		v_wide = CNT_WIDE_W'(vcnt_q);
		i_wide = CNT_WIDE_W'(icnt_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= num;
			den_q  <= den;
			quo_q  <= '0;
			dcnt_q <= '0;
			zero_q <= (vcnt_q == '0) && (icnt_q == '0);
		end else if (cmd.div_step) begin
			if (ge) rem_q <= rem_q - den_q;
			den_q  <= den_q >> 1;
			quo_q  <= {quo_q[PCT_W-2:0], ge};
			dcnt_q <= dcnt_q + 3'd1;
		end
		if (cmd.out_load) begin
			vout_q <= v_wide[OUT_CNT_W-1:0];
			iout_q <= i_wide[OUT_CNT_W-1:0];
			pct_q  <= zero_q ? '0 : quo_q;
		end
	end

	assign valid_sequences = vout_q;
	assign invalid_bytes   = iout_q;
	assign percent_valid   = pct_q;

endmodule

// ===== design/utf8_likelihood_scorer.sv =====
// Throughput: one byte beat per cycle while a short lead waits for more bytes; every head
// decision (ASCII skip, invalid byte, finished sequence) is made with in_ready low.
// After the last byte beat the scorer makes its drain decisions, leaves S_PROC, sets up the
// division (S_PREP), runs it (S_DIV) and captures the result (S_HOLD), which is then offered.
// Reset (arst_n low, async): window empty, counters zero, no result pending.
// Depends on uls_pkg, uls_ctrl, uls_dp.
module utf8_likelihood_scorer import uls_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = ULS_COUNT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input beats: one text byte each
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	// result beats: one per stream, after its last byte
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_CNT_W-1:0] valid_sequences,
	output logic [OUT_CNT_W-1:0] invalid_bytes,
	output logic [PCT_W-1:0]     percent_valid
);

	uls_cmd_t cmd;
	uls_sts_t sts;

	// Controller: takes a byte only when the window head cannot be decided
	// further; on the last byte it drains, divides and hands the result over.
	uls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Datapath: six-byte window with variable shift, saturating counters,
	// shift-add numerator and bit-per-cycle divider, output register.
	// The result register frees the scorer to start the next stream while
	// the previous result still waits.
	uls_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.data_byte       (data_byte),
		.valid_sequences (valid_sequences),
		.invalid_bytes   (invalid_bytes),
		.percent_valid   (percent_valid)
	);

endmodule

// ===== design/uls_checker.sv =====
// uls_checker: port-level assertions for utf8_likelihood_scorer, bound to the top.
// Depends on uls_pkg.
module uls_checker import uls_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 last_byte,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_CNT_W-1:0] valid_sequences,
	input logic [OUT_CNT_W-1:0] invalid_bytes,
	input logic [PCT_W-1:0]     percent_valid
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(valid_sequences)
			&& $stable(invalid_bytes) && $stable(percent_valid))
		else $error("result beat changed while stalled");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent_valid <= PCT_SCALE)
		else $error("percent above 100");

	// after the last byte the scorer must drain before taking more
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte |=> !in_ready)
		else $error("beat taken right after last byte");

	// a new result only comes out of the drain/divide sequence
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while taking input");

endmodule

bind utf8_likelihood_scorer uls_checker u_uls_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.last_byte       (last_byte),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.valid_sequences (valid_sequences),
	.invalid_bytes   (invalid_bytes),
	.percent_valid   (percent_valid)
);
